/* design/arfp_pkg.sv */
// Package for the ASCII reading frame parser.
// Holds window sizes, character codes, shared types and the decode result struct.
// No dependencies.
package arfp_pkg;

  localparam int WINDOW_BYTES = 12;
  localparam int FRAME_BYTES  = 8;
  localparam int VALUE_W      = 18;
  localparam int READING_W    = 16;
  localparam int COUNT_W      = 8;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [3:0] HI_DIGIT = 4'h3;

  localparam logic [READING_W-1:0] MAX_READING_RESET = '1;

  typedef logic [7:0]                    byte_t;
  typedef logic [WINDOW_BYTES-1:0][7:0]  window_t;
  typedef logic [FRAME_BYTES-1:0][7:0]   frame_t;
  typedef logic [READING_W-1:0]          reading_t;
  typedef logic [COUNT_W-1:0]            count_t;
  typedef logic [VALUE_W-1:0]            value_t;

  typedef struct packed {
    logic   found;
    value_t value;
  } match_t;

endpackage

/* design/arfp_if.sv */
// Handshake channel interfaces for the ASCII reading frame parser.
// Byte input, reading output and configuration write channels.
// Depends on arfp_pkg.
interface arfp_rx_if;
  logic             valid;
  logic             ready;
  arfp_pkg::byte_t  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface arfp_res_if;
  logic               valid;
  logic               ready;
  arfp_pkg::reading_t reading;
  logic               frame_found;
  arfp_pkg::count_t   frame_count;

  modport source (output valid, output reading, output frame_found, output frame_count,
                  input ready);
  modport sink (input valid, input reading, input frame_found, input frame_count,
                output ready);
endinterface

interface arfp_cfg_if;
  logic               valid;
  logic               ready;
  arfp_pkg::reading_t max_reading;

  modport source (output valid, output max_reading, input ready);
  modport sink (input valid, input max_reading, output ready);
endinterface

/* design/arfp_cell.sv */
// One byte cell of the receive window shift chain.
// Loads its neighbor's byte on each shift, with an optional clear.
// Depends on arfp_pkg.
module arfp_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  logic            clear,
  input  arfp_pkg::byte_t din,
  output arfp_pkg::byte_t dout
);
  import arfp_pkg::*;

  byte_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else if (shift) begin
      data <= clear ? '0 : din;
    end
  end

  assign dout = data;

endmodule

/* design/arfp_match.sv */
// Frame shape matcher and decimal decoder for the ASCII reading frame parser.
// Tests the three frame shapes in priority order and weights the digit nibbles.
// Depends on arfp_pkg.
module arfp_match (
  input  arfp_pkg::frame_t frame,
  output arfp_pkg::match_t match
);
  import arfp_pkg::*;

  logic   tail;
  logic   three_digit;
  logic   four_digit;
  logic   five_digit;
  value_t val3;
  value_t val4;
  value_t val5;

  function automatic value_t nib(input byte_t b);
    return VALUE_W'(b[3:0]);
  endfunction

  always_comb begin
    tail        = (frame[6] == CH_SPACE) && (frame[7] == CH_P);
    three_digit = tail && (frame[1] == CH_SPACE) && (frame[2] == CH_SPACE);
    four_digit  = tail && (frame[1] == CH_SPACE) && (frame[2][7:4] == HI_DIGIT);
    five_digit  = tail && (frame[0] == CH_SPACE) && (frame[1][7:4] == HI_DIGIT);

    val3 = VALUE_W'(nib(frame[3]) * VALUE_W'(100) + nib(frame[4]) * VALUE_W'(10)
                    + nib(frame[5]));
    val4 = VALUE_W'(nib(frame[2]) * VALUE_W'(1000) + val3);
    val5 = VALUE_W'(nib(frame[1]) * VALUE_W'(10000) + val4);

    match.found = three_digit || four_digit || five_digit;
    if (three_digit) begin
      match.value = val3;
    end else if (four_digit) begin
      match.value = val4;
    end else begin
      match.value = val5;
    end
  end

endmodule

/* design/ascii_reading_frame_parser.sv */
// ASCII reading frame parser top level: byte window chain, matcher and result register.
// A result is valid in the cycle after its byte request is accepted.
// Throughput: one byte per cycle while the single output register is empty or res.ready drains it.
// Reset clears the window, held reading, frame count and output valid;
// max_reading resets to 65535. Depends on arfp_pkg, arfp_if, arfp_cell, arfp_match.
module ascii_reading_frame_parser (
  input logic       clk,
  input logic       rst,
  arfp_rx_if.sink   rx,
  arfp_res_if.source res,
  arfp_cfg_if.sink  cfg
);
  import arfp_pkg::*;

  window_t  win;
  window_t  win_next;
  frame_t   frame;
  match_t   m;
  logic     accept;
  reading_t max_reading;
  reading_t held_reading;
  reading_t held_reading_next;
  count_t   frames_seen;
  count_t   frames_seen_next;
  value_t   held_cand;
  logic     res_valid;
  logic     res_found;

  assign accept = rx.valid && rx.ready;
  assign rx.ready = !res_valid || res.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    for (int k = 0; k < WINDOW_BYTES - 1; k++) begin
      win_next[k] = win[k+1];
    end
    win_next[WINDOW_BYTES-1] = rx.rx_byte;
  end

  assign frame = win_next[FRAME_BYTES-1:0];

  for (genvar k = 0; k < WINDOW_BYTES; k++) begin : g_cell
    arfp_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (accept),
      .clear ((k == 0) && m.found),
      .din   (win_next[k]),
      .dout  (win[k])
    );
  end

  arfp_match u_match (
    .frame (frame),
    .match (m)
  );

  always_comb begin
    held_cand = m.found ? m.value : VALUE_W'(held_reading);
    if (held_cand > VALUE_W'(max_reading)) begin
      held_reading_next = max_reading;
    end else begin
      held_reading_next = held_cand[READING_W-1:0];
    end
    frames_seen_next = frames_seen + COUNT_W'(m.found);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_reading <= MAX_READING_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_reading <= cfg.max_reading;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_reading <= '0;
      frames_seen  <= '0;
      res_valid    <= 1'b0;
      res_found    <= 1'b0;
    end else begin
      if (accept) begin
        held_reading <= held_reading_next;
        frames_seen  <= frames_seen_next;
        res_found    <= m.found;
        res_valid    <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign res.valid       = res_valid;
  assign res.reading     = held_reading;
  assign res.frame_found = res_found;
  assign res.frame_count = frames_seen;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid after reset");
  a_accept_valid: assert property (@(posedge clk) disable iff (rst)
    accept |=> res.valid)
    else $error("accepted request produced no result");
  a_clamped: assert property (@(posedge clk) disable iff (rst)
    accept |=> held_reading <= $past(max_reading))
    else $error("held reading above configured maximum");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> frames_seen == COUNT_W'($past(frames_seen) + COUNT_W'($past(m.found))))
    else $error("frame count did not follow frame matches");
`endif

endmodule

/* dv/arfp_reading_check.sv */
// Checker for the ASCII reading frame parser: watches the byte, result and configuration channels.
// Predicts each result from its own copy of the byte window, held reading, frame count and cap.
// Depends on arfp_pkg and the channel interfaces in arfp_if.
module arfp_reading_check (
  input  logic        clk,
  input  logic        rst,
  arfp_rx_if          rx,
  arfp_res_if         res,
  arfp_cfg_if         cfg,
  output int unsigned outstanding,
  output int unsigned mismatches
);
  import arfp_pkg::*;

  typedef struct packed {
    reading_t reading;
    logic     frame_found;
    count_t   frame_count;
  } reading_result_t;

  byte_t           rx_window [WINDOW_BYTES];
  value_t          held_value;
  count_t          frame_tally;
  reading_t        reading_cap;
  reading_result_t awaited_readings [$];

  initial mismatches = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int nib(input int pos);
    return int'(rx_window[pos][3:0]);
  endfunction

  function automatic logic digit_hi(input int pos);
    return rx_window[pos][7:4] == HI_DIGIT;
  endfunction

  task automatic shift_and_decode(input byte_t b);
    reading_result_t r;
    int              val;
    logic            hit;
    logic            tail;
    for (int i = 0; i < WINDOW_BYTES - 1; i++) rx_window[i] = rx_window[i + 1];
    rx_window[WINDOW_BYTES - 1] = b;
    tail = rx_window[6] == CH_SPACE && rx_window[7] == CH_P;
    hit = 1'b1;
    val = 0;
    if (tail && rx_window[1] == CH_SPACE && rx_window[2] == CH_SPACE) begin
      val = nib(3) * 100 + nib(4) * 10 + nib(5);
    end else if (tail && rx_window[1] == CH_SPACE && digit_hi(2)) begin
      val = nib(2) * 1000 + nib(3) * 100 + nib(4) * 10 + nib(5);
    end else if (tail && rx_window[0] == CH_SPACE && digit_hi(1)) begin
      val = nib(1) * 10000 + nib(2) * 1000 + nib(3) * 100 + nib(4) * 10 + nib(5);
    end else begin
      hit = 1'b0;
    end
    if (hit) begin
      held_value = value_t'(val);
      rx_window[0] = '0;
      frame_tally = frame_tally + 1'b1;
    end
    if (held_value > value_t'(reading_cap)) held_value = value_t'(reading_cap);
    r.reading = held_value[READING_W-1:0];
    r.frame_found = hit;
    r.frame_count = frame_tally;
    awaited_readings.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    reading_result_t head;
    if (rst) begin
      foreach (rx_window[i]) rx_window[i] = '0;
      held_value = '0;
      frame_tally = '0;
      reading_cap = MAX_READING_RESET;
      awaited_readings.delete();
      outstanding <= 0;
    end else begin
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        if (awaited_readings.size() == 0) begin
          report_mismatch("unrequested result", res.reading, 0);
        end else begin
          head = awaited_readings.pop_front();
          if (res.reading !== head.reading)
            report_mismatch("reading", res.reading, head.reading);
          if (res.frame_found !== head.frame_found)
            report_mismatch("frame_found", res.frame_found, head.frame_found);
          if (res.frame_count !== head.frame_count)
            report_mismatch("frame_count", res.frame_count, head.frame_count);
        end
      end
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) reading_cap = cfg.max_reading;
      if (rx.valid === 1'b1 && rx.ready === 1'b1) shift_and_decode(rx.rx_byte);
      outstanding <= awaited_readings.size();
    end
  end

endmodule

/* dv/tb_ascii_reading_frame_parser.sv */
// Testbench top for the ASCII reading frame parser: clock, reset, byte and configuration stimulus.
// Result checking is done by arfp_reading_check; this module only drives requests, result ready and reports.
// Depends on arfp_pkg, arfp_if, arfp_reading_check and the block itself.
module tb_ascii_reading_frame_parser;
  import arfp_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 6;
  localparam int PHASE_FRAMES = 25;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          gaps_on = 1'b0;
  bit          hold_req = 1'b0;

  arfp_rx_if  rx ();
  arfp_res_if res ();
  arfp_cfg_if cfg ();

  ascii_reading_frame_parser uut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .res (res),
    .cfg (cfg)
  );

  arfp_reading_check frame_check (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx),
    .res         (res),
    .cfg         (cfg),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if ((rx.valid === 1'b1 && rx.ready === 1'b1) || (res.valid === 1'b1 && res.ready === 1'b1)
        || (cfg.valid === 1'b1 && cfg.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_ascii_reading_frame_parser: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    res.ready <= 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        res.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        res.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic put_byte(input byte_t b);
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
      rx.valid <= 1'b0;
      rx.rx_byte <= byte_t'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (rx.ready !== 1'b1);
  endtask

  task automatic put_bytes(input byte_t f [8]);
    foreach (f[i]) put_byte(f[i]);
  endtask

  task automatic wait_drained();
    rx.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_cap(input reading_t v);
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.max_reading <= v;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    cfg.valid <= 1'b0;
  endtask

  function automatic byte_t digit_byte();
    case ($urandom_range(0, 9))
      0:       return {HI_DIGIT, 4'($urandom_range(10, 15))};
      1:       return byte_t'($urandom);
      default: return {HI_DIGIT, 4'($urandom_range(0, 9))};
    endcase
  endfunction

  function automatic byte_t lead_byte();
    if ($urandom_range(0, 5) == 0) return {HI_DIGIT, 4'($urandom_range(10, 15))};
    return {HI_DIGIT, 4'($urandom_range(0, 9))};
  endfunction

  function automatic byte_t noise_byte();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_P;
      2:       return {HI_DIGIT, 4'($urandom)};
      default: return byte_t'($urandom);
    endcase
  endfunction

  // Sends one frame of the given digit count, optionally with one byte corrupted.
  task automatic put_frame(input int digits, input bit broken);
    byte_t f [8];
    f[0] = ($urandom_range(0, 1) == 0) ? CH_SPACE : noise_byte();
    f[1] = CH_SPACE;
    f[2] = CH_SPACE;
    for (int i = 3; i < 6; i++) f[i] = digit_byte();
    f[6] = CH_SPACE;
    f[7] = CH_P;
    if (digits == 4) begin
      f[2] = lead_byte();
    end else if (digits == 5) begin
      f[0] = CH_SPACE;
      f[1] = lead_byte();
      f[2] = digit_byte();
    end
    if (broken) f[$urandom_range(0, 7)] ^= byte_t'($urandom_range(1, 255));
    put_bytes(f);
  endtask

  initial begin
    reading_t caps [PHASES];
    int       frames_done;
    int       pick;
    rst = 1'b1;
    rx.valid = 1'b0;
    rx.rx_byte = '0;
    cfg.valid = 1'b0;
    cfg.max_reading = '0;
    caps = '{16'h0000, 16'd999, reading_t'($urandom), 16'hFFFF, 16'h0001,
             reading_t'($urandom)};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    put_bytes('{8'h00, CH_SPACE, CH_SPACE, 8'h39, 8'h39, 8'h39, CH_SPACE, CH_P});
    put_bytes('{8'hFF, CH_SPACE, 8'h30, 8'h30, 8'h30, 8'h30, CH_SPACE, CH_P});
    put_bytes('{CH_SPACE, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, CH_SPACE, CH_P});
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CH_P);
    put_byte(CH_SPACE);

    for (int p = 0; p < PHASES; p++) begin
      write_cap(caps[p]);
      if (p == 1) hold_req = 1'b1;
      if (p == PHASES - 1) quiet = 1'b1;
      frames_done = 0;
      while (frames_done < PHASE_FRAMES) begin
        gaps_on = $urandom_range(0, 1);
        pick = $urandom_range(0, 19);
        if (pick < 16) begin
          put_frame($urandom_range(3, 5), 1'b0);
          frames_done++;
        end else if (pick < 18) begin
          put_frame($urandom_range(3, 5), 1'b1);
        end else begin
          repeat ($urandom_range(1, 6)) put_byte(noise_byte());
        end
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_ascii_reading_frame_parser: clean");
    end else begin
      $display("tb_ascii_reading_frame_parser: errors");
    end
    $finish;
  end

endmodule
